// File: rtl/core/rbdg_pkg.sv
package rbdg_pkg;

  localparam int MAX_COLUMNS_DEF   = 256;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int GLYPH_LEVELS_DEF  = 8;

  // configuration register widths
  localparam int CFG_W = 13;
  localparam int FW_W  = 13;
  localparam int FH_W  = 13;
  localparam int CC_W  = 9;
  localparam int CR_W  = 8;
  localparam int IDX_W = 2;

  localparam logic [FW_W-1:0] FW_RESET = 13'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;
  localparam logic [CC_W-1:0] CC_RESET = 9'd80;
  localparam logic [CR_W-1:0] CR_RESET = 8'd24;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_CONSOLE_COLUMNS = 2'd2,
    CFG_CONSOLE_ROWS    = 2'd3
  } cfg_index_t;

  // luma = (30r + 59g + 11b) / 100, the divide done as * 5243 >> 19
  localparam int NUM_W      = 15;
  localparam int LPROD_W    = 28;
  localparam int LUMA_R     = 30;
  localparam int LUMA_G     = 59;
  localparam int LUMA_B     = 11;
  localparam int LUMA_RECIP = 5243;
  localparam int LUMA_SHIFT = 19;

  localparam int SUM_W = 32;

  localparam int GLYPH_IDX_W = 3;
  localparam logic [7:0] GLYPH_TABLE [8] = '{
    8'h20, 8'h2E, 8'h3B, 8'h6F, 8'h2A, 8'h38, 8'h24, 8'h40
  };
  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    DIV_COLS = 2'd0,
    DIV_ROWS = 2'd1,
    DIV_LAST = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     cs_load;
    logic     rs_load;
    logic     lf_load;
    logic     mul_load;
    logic     unit_load;
    logic     thr_step;
    logic     pix_load;
    logic     luma_calc;
    logic     luma_scale;
    logic     acc;
    logic     finish;
  } rbdg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic thr_done;
    logic has_result;
    logic out_busy;
  } rbdg_status_t;

endpackage

// File: rtl/core/rbdg_if.sv
interface rbdg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface rbdg_glyph_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;
  logic       frame_end;

  modport source(output valid, output char_code, output line_end, output frame_end,
                 input ready);
  modport sink(input valid, input char_code, input line_end, input frame_end,
               output ready);
endinterface

// File: rtl/core/rbdg_div.sv
module rbdg_div #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dsor;
  logic [W:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[W-1]};
  assign fits   = rem_sh >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem      <= W'(rem_sh - {1'b0, dsor});
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[W-1:0];
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/rbdg_dp.sv
module rbdg_dp #(
  parameter int MAX_COLUMNS   = rbdg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_DIMENSION = rbdg_pkg::MAX_DIMENSION_DEF,
  parameter int GLYPH_LEVELS  = rbdg_pkg::GLYPH_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [rbdg_pkg::IDX_W-1:0] cfg_index,
  input  logic [rbdg_pkg::CFG_W-1:0] cfg_data,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  rbdg_pkg::rbdg_cmd_t        cmd,
  output rbdg_pkg::rbdg_status_t     status,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [7:0]                 char_code,
  output logic                       line_end,
  output logic                       frame_end
);

  localparam int PW    = $clog2(MAX_DIMENSION);
  localparam int CW    = $clog2(MAX_DIMENSION + 2);
  localparam int DVW   = (CW > rbdg_pkg::CC_W) ? CW : rbdg_pkg::CC_W;
  localparam int BW    = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH = MAX_COLUMNS + 1;
  localparam int PRW   = 2 * CW;
  localparam int TW    = 2 * CW + 8;
  localparam int CMPW  = (TW > rbdg_pkg::SUM_W) ? TW : rbdg_pkg::SUM_W;
  localparam int LW    = $clog2(GLYPH_LEVELS);
  localparam int STEP  = 256 / GLYPH_LEVELS;
  localparam int SW    = rbdg_pkg::SUM_W;

  logic [rbdg_pkg::FW_W-1:0] fw_r;
  logic [rbdg_pkg::FH_W-1:0] fh_r;
  logic [rbdg_pkg::CC_W-1:0] cc_r;
  logic [rbdg_pkg::CR_W-1:0] cr_r;

  logic [CW-1:0]  fw_c;
  logic [CW-1:0]  fh_c;
  logic [DVW-1:0] cc_c;
  logic [DVW-1:0] cr_c;

  logic [DVW-1:0] div_a;
  logic [DVW-1:0] div_b;
  logic [DVW-1:0] div_q;
  logic           div_done;

  logic [CW-1:0]  cs;
  logic [CW-1:0]  rs;
  logic [BW-1:0]  lf;
  logic [PRW-1:0] prod;
  logic [TW-1:0]  unit;
  logic [TW-1:0]  thr_acc;
  logic [TW-1:0]  thr [GLYPH_LEVELS-1];
  logic [LW-1:0]  thr_cnt;

  logic [7:0]                   r_q;
  logic [7:0]                   g_q;
  logic [7:0]                   b_q;
  logic [rbdg_pkg::NUM_W-1:0]   num;
  logic [rbdg_pkg::LPROD_W-1:0] luma_prod;
  logic [7:0]                   luma;

  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    mem_q;
  logic [DEPTH-1:0] vld;
  logic             vld_q;
  logic [SW-1:0]    base;
  logic [SW:0]      sum_wide;
  logic [SW-1:0]    sum_sat;
  logic [SW-1:0]    sum;

  logic [PW-1:0] column;
  logic [PW-1:0] row;
  logic [PW-1:0] offset;
  logic [PW-1:0] rib;
  logic [BW-1:0] bidx;

  logic flush_row;
  logic at_line;
  logic last_row;
  logic glyph_now;
  logic glyph_q;
  logic line_q;
  logic flush_q;
  logic last_row_q;
  logic frame_done;
  logic newline;
  logic wipe;

  logic [LW-1:0] lvl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_r <= rbdg_pkg::FW_RESET;
      fh_r <= rbdg_pkg::FH_RESET;
      cc_r <= rbdg_pkg::CC_RESET;
      cr_r <= rbdg_pkg::CR_RESET;
    end else if (cfg_write) begin
      unique case (rbdg_pkg::cfg_index_t'(cfg_index))
        rbdg_pkg::CFG_FRAME_WIDTH:     fw_r <= cfg_data;
        rbdg_pkg::CFG_FRAME_HEIGHT:    fh_r <= cfg_data;
        rbdg_pkg::CFG_CONSOLE_COLUMNS: cc_r <= cfg_data[rbdg_pkg::CC_W-1:0];
        rbdg_pkg::CFG_CONSOLE_ROWS:    cr_r <= cfg_data[rbdg_pkg::CR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      fw_c = CW'(1);
    end else if (32'(fw_r) > MAX_DIMENSION) begin
      fw_c = CW'(MAX_DIMENSION);
    end else begin
      fw_c = CW'(fw_r);
    end
    if (fh_r == '0) begin
      fh_c = CW'(1);
    end else if (32'(fh_r) > MAX_DIMENSION) begin
      fh_c = CW'(MAX_DIMENSION);
    end else begin
      fh_c = CW'(fh_r);
    end
    if (cc_r == '0) begin
      cc_c = DVW'(1);
    end else if (32'(cc_r) > MAX_COLUMNS) begin
      cc_c = DVW'(MAX_COLUMNS);
    end else begin
      cc_c = DVW'(cc_r);
    end
    if (cr_r == '0) begin
      cr_c = DVW'(1);
    end else begin
      cr_c = DVW'(cr_r);
    end
  end

  // step sizes and glyph thresholds
  always_comb begin
    case (cmd.div_sel)
      rbdg_pkg::DIV_COLS: begin
        div_a = DVW'(fw_c);
        div_b = cc_c;
      end
      rbdg_pkg::DIV_ROWS: begin
        div_a = DVW'(fh_c);
        div_b = cr_c;
      end
      rbdg_pkg::DIV_LAST: begin
        div_a = DVW'(fw_c - CW'(1));
        div_b = DVW'(cs);
      end
      default: begin
        div_a = DVW'(fw_c);
        div_b = cc_c;
      end
    endcase
  end

  rbdg_div #(.W(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cs_load) cs <= CW'(div_q) + CW'(1);
    if (cmd.rs_load) rs <= CW'(div_q) + CW'(1);
    if (cmd.lf_load) lf <= BW'(div_q);
    if (cmd.mul_load) prod <= PRW'(cs) * PRW'(rs);
    if (cmd.unit_load) begin
      unit    <= TW'(prod) * TW'(STEP);
      thr_acc <= TW'(prod) * TW'(STEP);
      thr_cnt <= '0;
    end else if (cmd.thr_step) begin
      thr[GLYPH_LEVELS-2] <= thr_acc;
      for (int k = 0; k < GLYPH_LEVELS - 2; k++) begin
        thr[k] <= thr[k+1];
      end
      thr_acc <= thr_acc + unit;
      thr_cnt <= thr_cnt + LW'(1);
    end
  end

  // pixel path
  assign luma_prod = rbdg_pkg::LPROD_W'(num) * rbdg_pkg::LPROD_W'(rbdg_pkg::LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      r_q <= red;
      g_q <= green;
      b_q <= blue;
    end
    if (cmd.luma_calc) begin
      num <= rbdg_pkg::NUM_W'(r_q) * rbdg_pkg::NUM_W'(rbdg_pkg::LUMA_R)
           + rbdg_pkg::NUM_W'(g_q) * rbdg_pkg::NUM_W'(rbdg_pkg::LUMA_G)
           + rbdg_pkg::NUM_W'(b_q) * rbdg_pkg::NUM_W'(rbdg_pkg::LUMA_B);
    end
    if (cmd.luma_scale) luma <= luma_prod[rbdg_pkg::LUMA_SHIFT +: 8];
  end

  assign flush_row = (row != '0) && ((rib == '0) || last_row);
  assign last_row  = CW'(row) == fh_c - CW'(1);
  assign at_line   = CW'(column) + CW'(1) >= fw_c;
  assign glyph_now = flush_row && (CW'(offset) == cs - CW'(1)) && (bidx < lf);

  assign base     = vld_q ? mem_q : '0;
  assign sum_wide = {1'b0, base} + (SW + 1)'(luma);
  assign sum_sat  = sum_wide[SW] ? '1 : sum_wide[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.acc) mem[bidx] <= glyph_now ? '0 : sum_sat;
    if (cmd.luma_calc) begin
      mem_q <= mem[bidx];
      vld_q <= vld[bidx];
    end
    if (cmd.acc) begin
      sum        <= sum_sat;
      glyph_q    <= glyph_now;
      line_q     <= at_line;
      flush_q    <= flush_row;
      last_row_q <= last_row;
    end
  end

  assign frame_done = line_q && (CW'(row) + CW'(1) >= fh_c);
  assign newline    = line_q && flush_q;
  assign wipe       = cmd.finish && line_q && (flush_q || frame_done);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      vld <= '0;
    end else if (wipe) begin
      vld <= '0;
    end else if (cmd.acc) begin
      vld[bidx] <= 1'b1;
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || cfg_write || (cmd.finish && frame_done)) begin
      column <= '0;
      row    <= '0;
      offset <= '0;
      rib    <= '0;
      bidx   <= '0;
    end else if (cmd.finish) begin
      if (line_q) begin
        column <= '0;
        offset <= '0;
        bidx   <= '0;
        row    <= row + PW'(1);
        if (CW'(rib) + CW'(1) >= rs) begin
          rib <= '0;
        end else begin
          rib <= rib + PW'(1);
        end
      end else begin
        column <= column + PW'(1);
        if (CW'(offset) + CW'(1) >= cs) begin
          offset <= '0;
          if (bidx != BW'(MAX_COLUMNS)) bidx <= bidx + BW'(1);
        end else begin
          offset <= offset + PW'(1);
        end
      end
    end
  end

  // level = number of thresholds reached
  always_comb begin
    lvl = '0;
    for (int k = 0; k < GLYPH_LEVELS - 1; k++) begin
      if (CMPW'(sum) >= CMPW'(thr[k])) lvl = LW'(k + 1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish && status.has_result) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && status.has_result) begin
      char_code <= newline ? rbdg_pkg::NEWLINE
                           : rbdg_pkg::GLYPH_TABLE[rbdg_pkg::GLYPH_IDX_W'(lvl)];
      line_end  <= newline;
      frame_end <= newline && last_row_q;
    end
  end

  assign status.div_done   = div_done;
  assign status.thr_done   = thr_cnt == LW'(GLYPH_LEVELS - 2);
  assign status.has_result = glyph_q || newline;
  assign status.out_busy   = out_valid && !out_ready;

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && status.has_result) |-> (!out_valid || out_ready))
    else $error("result loaded over an undelivered one");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(column) < fw_c)
    else $error("pixel column past frame width");

  a_glyph_not_line: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> !(glyph_now && at_line))
    else $error("glyph emitted from the trailing bucket");

endmodule

// File: rtl/core/rbdg_ctrl.sv
module rbdg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rbdg_pkg::rbdg_status_t status,
  output rbdg_pkg::rbdg_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_START   = 12'b000000000001,
    S_CS_WAIT = 12'b000000000010,
    S_RS_WAIT = 12'b000000000100,
    S_LF_WAIT = 12'b000000001000,
    S_MUL     = 12'b000000010000,
    S_SCALE   = 12'b000000100000,
    S_THR     = 12'b000001000000,
    S_IDLE    = 12'b000010000000,
    S_LUMA    = 12'b000100000000,
    S_FETCH   = 12'b001000000000,
    S_ACC     = 12'b010000000000,
    S_EMIT    = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = rbdg_pkg::DIV_COLS;
    in_ready    = 1'b0;
    state_next  = state;
    unique case (state)
      S_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rbdg_pkg::DIV_COLS;
        state_next    = S_CS_WAIT;
      end
      S_CS_WAIT: begin
        if (status.div_done) begin
          cmd.cs_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = rbdg_pkg::DIV_ROWS;
          state_next    = S_RS_WAIT;
        end
      end
      S_RS_WAIT: begin
        if (status.div_done) begin
          cmd.rs_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = rbdg_pkg::DIV_LAST;
          state_next    = S_LF_WAIT;
        end
      end
      S_LF_WAIT: begin
        cmd.div_sel = rbdg_pkg::DIV_LAST;
        if (status.div_done) begin
          cmd.lf_load = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.unit_load = 1'b1;
        state_next    = S_THR;
      end
      S_THR: begin
        cmd.thr_step = 1'b1;
        if (status.thr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !cfg_write;
        if (in_valid && !cfg_write) begin
          cmd.pix_load = 1'b1;
          state_next   = S_LUMA;
        end
      end
      S_LUMA: begin
        cmd.luma_calc = 1'b1;
        state_next    = S_FETCH;
      end
      S_FETCH: begin
        cmd.luma_scale = 1'b1;
        state_next     = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!(status.has_result && status.out_busy)) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_START;
    endcase
    if (cfg_write) state_next = S_START;
  end

endmodule

// File: rtl/core/rgb_box_downscale_to_glyphs.sv
// Box-downsampled glyph art. RGB pixels enter in raster order on "pixels";
// each becomes integer luma, is summed into its column bucket, and on the
// first row of each later band and on the frame's last row a finished bucket
// leaves "glyphs" as one character, with a newline at the end of that row. A
// pixel steps through accept, luma product with the bucket read, luma scale,
// accumulate and write back, and result; the read-modify-write of the bucket
// memory sets this sequence, a result waiting in the output register holds the
// result step, and the next pixel is taken only after it. After reset and
// after every configuration write the block derives the bucket sizes with a
// bit-serial divider and the glyph thresholds, and takes no pixel meanwhile.
// Bucket sums are cleared through per-entry valid bits, so no clearing pass
// is needed.
module rgb_box_downscale_to_glyphs #(
  parameter int MAX_COLUMNS   = rbdg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_DIMENSION = rbdg_pkg::MAX_DIMENSION_DEF,
  parameter int GLYPH_LEVELS  = rbdg_pkg::GLYPH_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [rbdg_pkg::IDX_W-1:0] cfg_index,
  input  logic [rbdg_pkg::CFG_W-1:0] cfg_data,
  rbdg_pix_if.sink                   pixels,
  rbdg_glyph_if.source               glyphs
);

  rbdg_pkg::rbdg_cmd_t    cmd;
  rbdg_pkg::rbdg_status_t status;
  logic                   in_ready;

  assign pixels.ready = in_ready;

  rbdg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_valid  (pixels.valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rbdg_dp #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_DIMENSION (MAX_DIMENSION),
    .GLYPH_LEVELS  (GLYPH_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .red       (pixels.red),
    .green     (pixels.green),
    .blue      (pixels.blue),
    .cmd       (cmd),
    .status    (status),
    .out_ready (glyphs.ready),
    .out_valid (glyphs.valid),
    .char_code (glyphs.char_code),
    .line_end  (glyphs.line_end),
    .frame_end (glyphs.frame_end)
  );

endmodule
